>>> design/pws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wavetable synth package
// Shared constants, request codes, command and status types, and the pitch
// bend factor table.
// ----------------------------------------------------------------------------
package pws_pkg;

	localparam int NumVoices   = 15;
	localparam int WaveEntries = 1024;
	localparam int KeyCount    = 128;
	localparam int VoiceW      = $clog2(NumVoices);
	localparam int WaveAw      = $clog2(WaveEntries);
	localparam int PhaseW      = WaveAw + 16;
	localparam int StepW       = 26;
	localparam int SumW        = 32;

	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_ON    = 3'd1;
	localparam logic [2:0] REQ_OFF   = 3'd2;
	localparam logic [2:0] REQ_WHEEL = 3'd3;
	localparam logic [2:0] REQ_WAVE  = 3'd4;
	localparam logic [2:0] REQ_STEP  = 3'd5;

	// Operation the datapath performs on the voice it is told to visit.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_TICK,
		OP_ON,
		OP_OFF,
		OP_WHEEL
	} op_t;

	typedef struct packed {
		logic              start;   // clear accumulator, latch request
		logic              visit;   // work on voice idx (read stage)
		op_t               op;
		logic [VoiceW-1:0] idx;
		logic              finish;  // form the DAC code
	} dp_cmd_t;

	typedef struct packed {
		logic busy;  // pipeline still holds work
		logic hit;   // a matching voice was written (on/off stop search)
	} dp_stat_t;

	function automatic logic [16:0] bend_factor(input logic [5:0] i);
		logic [16:0] r;
		case (i)
			6'd0: r = 17'd61858;  6'd1: r = 17'd61970;  6'd2: r = 17'd62081;
			6'd3: r = 17'd62194;  6'd4: r = 17'd62306;  6'd5: r = 17'd62419;
			6'd6: r = 17'd62531;  6'd7: r = 17'd62644;  6'd8: r = 17'd62757;
			6'd9: r = 17'd62871;  6'd10: r = 17'd62984; 6'd11: r = 17'd63098;
			6'd12: r = 17'd63212; 6'd13: r = 17'd63326; 6'd14: r = 17'd63441;
			6'd15: r = 17'd63556; 6'd16: r = 17'd63670; 6'd17: r = 17'd63785;
			6'd18: r = 17'd63901; 6'd19: r = 17'd64016; 6'd20: r = 17'd64132;
			6'd21: r = 17'd64248; 6'd22: r = 17'd64364; 6'd23: r = 17'd64480;
			6'd24: r = 17'd64596; 6'd25: r = 17'd64713; 6'd26: r = 17'd64830;
			6'd27: r = 17'd64947; 6'd28: r = 17'd65065; 6'd29: r = 17'd65182;
			6'd30: r = 17'd65300; 6'd31: r = 17'd65418; 6'd32: r = 17'd65536;
			6'd33: r = 17'd65654; 6'd34: r = 17'd65773; 6'd35: r = 17'd65892;
			6'd36: r = 17'd66011; 6'd37: r = 17'd66130; 6'd38: r = 17'd66250;
			6'd39: r = 17'd66369; 6'd40: r = 17'd66489; 6'd41: r = 17'd66609;
			6'd42: r = 17'd66730; 6'd43: r = 17'd66850; 6'd44: r = 17'd66971;
			6'd45: r = 17'd67092; 6'd46: r = 17'd67213; 6'd47: r = 17'd67335;
			6'd48: r = 17'd67456; 6'd49: r = 17'd67578; 6'd50: r = 17'd67700;
			6'd51: r = 17'd67823; 6'd52: r = 17'd67945; 6'd53: r = 17'd68068;
			6'd54: r = 17'd68191; 6'd55: r = 17'd68314; 6'd56: r = 17'd68438;
			6'd57: r = 17'd68561; 6'd58: r = 17'd68685; 6'd59: r = 17'd68809;
			6'd60: r = 17'd68933; 6'd61: r = 17'd69058; 6'd62: r = 17'd69183;
			default: r = 17'd69308;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/pws_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wavetable synth datapath
// Voice register file, wave and step memories, and a short pipeline that
// updates one voice per cycle and accumulates the mix.
// ----------------------------------------------------------------------------
module pws_datapath import pws_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           cmd,
	output dp_stat_t               stat,
	input  wire logic [3:0]        channel,
	input  wire logic [6:0]        key,
	input  wire logic [6:0]        velocity,
	input  wire logic [13:0]       wheel_value,
	input  wire logic [9:0]        table_index,
	input  wire logic signed [15:0] wave_data,
	input  wire logic [StepW-1:0]  step_data,
	input  wire logic              load_wave,
	input  wire logic              load_step,
	output logic [11:0]            dac_code
);

	// Voice state.
	logic [NumVoices-1:0] active_q;
	logic [6:0]        key_q   [NumVoices];
	logic [3:0]        chan_q  [NumVoices];
	logic [6:0]        vol_q   [NumVoices];
	logic [StepW-1:0]  step_q  [NumVoices];
	logic [PhaseW-1:0] phase_q [NumVoices];

	// Memories.
	logic signed [15:0] wave_mem [WaveEntries];
	logic [StepW-1:0]   step_mem [KeyCount];

	// Latched request fields.
	logic [3:0]  chan_r_q;
	logic [6:0]  key_r_q;
	logic [6:0]  vel_r_q;
	logic [16:0] factor_q;
	logic signed [SumW-1:0] sum_q;

	// Stage 1: voice visit with memory reads in flight.
	logic              v_s1;
	op_t               op_s1;
	logic [VoiceW-1:0] idx_s1;
	logic [StepW-1:0]  kstep_s1;
	logic signed [15:0] samp_s1;
	logic [6:0]        vol_s1;
	// Stage 2: products.
	logic              v_s2;
	op_t               op_s2;
	logic [VoiceW-1:0] idx_s2;
	logic [42:0]       bend_s2;
	logic signed [23:0] mix_s2;
	logic              fin_s1, fin_s2, fin_s3;

	logic [PhaseW-1:0] nphase;
	logic [6:0]        rkey;

	assign nphase = phase_q[cmd.idx] + step_q[cmd.idx][PhaseW-1:0];
	// Step reads on note on use the request key; wheel uses the voice key.
	assign rkey = (cmd.op == OP_WHEEL) ? key_q[cmd.idx] : key_r_q;

	// Request latch and memory loads.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			chan_r_q <= channel;
			key_r_q  <= key;
			vel_r_q  <= velocity;
			factor_q <= bend_factor(wheel_value[13:8]);
		end
		if (load_wave && ({22'd0, table_index} < 32'(WaveEntries)))
			wave_mem[table_index[WaveAw-1:0]] <= wave_data;
		if (load_step && table_index < 10'(KeyCount))
			step_mem[table_index[6:0]] <= step_data;
		kstep_s1 <= step_mem[rkey];
		samp_s1  <= wave_mem[nphase[PhaseW-1:16]];
	end

	// Visit decision: selects the matching voice and writes its state.
	logic match;
	always_comb begin
		match = 1'b0;
		case (cmd.op)
			OP_TICK:  match = active_q[cmd.idx];
			OP_ON:    match = !active_q[cmd.idx];
			OP_OFF:   match = active_q[cmd.idx] && key_q[cmd.idx] == key_r_q;
			OP_WHEEL: match = active_q[cmd.idx] && chan_q[cmd.idx] == chan_r_q;
			default:  match = 1'b0;
		endcase
	end
	assign stat.hit  = cmd.visit && match &&
		(cmd.op == OP_ON || cmd.op == OP_OFF);
	assign stat.busy = v_s1 || v_s2;

	// Pipeline and voice state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0;
			fin_s1 <= 1'b0; fin_s2 <= 1'b0; fin_s3 <= 1'b0;
			op_s1 <= OP_NONE; op_s2 <= OP_NONE;
			for (int i = 0; i < NumVoices; i++) begin
				key_q[i] <= '0; chan_q[i] <= '0; vol_q[i] <= '0;
				step_q[i] <= '0; phase_q[i] <= '0;
			end
		end else begin
			v_s1   <= cmd.visit && match;
			op_s1  <= cmd.op;
			idx_s1 <= cmd.idx;
			vol_s1 <= vol_q[cmd.idx];
			fin_s1 <= cmd.finish;
			fin_s2 <= fin_s1;
			fin_s3 <= fin_s2;
			if (cmd.visit && match) begin
				case (cmd.op)
					OP_TICK: phase_q[cmd.idx] <= nphase;
					OP_ON: begin
						key_q[cmd.idx]   <= key_r_q;
						vol_q[cmd.idx]   <= vel_r_q;
						chan_q[cmd.idx]  <= chan_r_q;
						phase_q[cmd.idx] <= '0;
						active_q[cmd.idx] <= 1'b1;
					end
					OP_OFF: begin
						active_q[cmd.idx] <= 1'b0;
						chan_q[cmd.idx]   <= '0;
					end
					default: ;
				endcase
			end
			// Stage 1 to 2: multiply.
			v_s2    <= v_s1;
			op_s2   <= op_s1;
			idx_s2  <= idx_s1;
			bend_s2 <= kstep_s1 * factor_q;
			mix_s2  <= samp_s1 * $signed({1'b0, vol_s1});
			// Step writes: note on and off take the step memory word in stage 1, wheel the bent step in stage 2.
			if (v_s1 && (op_s1 == OP_ON || op_s1 == OP_OFF))
				step_q[idx_s1] <= kstep_s1;
			if (v_s2 && op_s2 == OP_WHEEL)
				step_q[idx_s2] <= (bend_s2[42:16] > 27'(2**StepW - 1)) ?
					{StepW{1'b1}} : bend_s2[StepW+15:16];
		end
	end

	// Mix accumulator and output code.
	logic signed [SumW-1:0] sh;
	assign sh = (sum_q >>> 10) + 32'sd2048;
	always_ff @(posedge clk) begin
		if (cmd.start)
			sum_q <= '0;
		else if (v_s2 && op_s2 == OP_TICK)
			sum_q <= sum_q + SumW'(mix_s2 >>> 4);
		if (fin_s3)
			dac_code <= sh < 0 ? 12'd0 : (sh > 32'sd4095 ? 12'd4095 : sh[11:0]);
	end

endmodule
`default_nettype wire

>>> design/pws_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wavetable synth controller
// Sequences one request: walks the voices, drains the pipeline and, for a
// tick, hands the DAC code to the output register.
// ----------------------------------------------------------------------------
module pws_ctrl import pws_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [2:0] req_type,
	input  wire logic [6:0] velocity,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	output dp_cmd_t         cmd,
	input  wire dp_stat_t   stat,
	output logic            load_wave,
	output logic            load_step
);

	typedef enum logic [2:0] { S_IDLE, S_WALK, S_DRAIN, S_FIN, S_OUT } state_t;

	state_t            state_q;
	op_t               op_q;
	logic [VoiceW-1:0] idx_q;
	logic [1:0]        wait_q;
	logic              accept;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != S_IDLE;
	assign load_wave = accept && req_type == REQ_WAVE;
	assign load_step = accept && req_type == REQ_STEP;

	op_t new_op;
	always_comb begin
		case (req_type)
			REQ_TICK:  new_op = OP_TICK;
			REQ_ON:    new_op = (velocity == 7'd0) ? OP_OFF : OP_ON;
			REQ_OFF:   new_op = OP_OFF;
			REQ_WHEEL: new_op = OP_WHEEL;
			default:   new_op = OP_NONE;
		endcase
	end

	always_comb begin
		cmd.start  = accept;
		cmd.visit  = state_q == S_WALK;
		cmd.op     = op_q;
		cmd.idx    = idx_q;
		cmd.finish = state_q == S_FIN;
	end

	// State and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_NONE;
			idx_q     <= '0;
			wait_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (accept && new_op != OP_NONE) begin
					op_q  <= new_op;
					idx_q <= '0;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (stat.hit || idx_q == VoiceW'(NumVoices - 1)) begin
						state_q <= S_DRAIN;
						wait_q  <= '0;
					end else
						idx_q <= idx_q + 1'b1;
				end
				S_DRAIN: begin
					if (!stat.busy && wait_q != 2'd0) begin
						state_q <= (op_q == OP_TICK) ? S_FIN : S_IDLE;
						wait_q  <= '0;
					end else
						wait_q <= wait_q + 1'b1;
				end
				S_FIN: begin
					wait_q <= wait_q + 1'b1;
					if (wait_q == 2'd3) begin
						out_valid <= 1'b1;
						state_q   <= S_OUT;
					end
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> design/polyphonic_wavetable_synth.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Polyphonic wavetable synth
// Fifteen wavetable voices with note, pitch wheel and table load requests,
// mixed to a 12-bit offset-binary DAC code on each tick.
// ----------------------------------------------------------------------------
// One input channel (in_valid/in_stall) carries a request word; the output
// channel (out_valid/out_stall) carries a DAC code word, one per tick only.
// Table loads are written when accepted. Note, note off, wheel and tick requests walk the
// voice file one voice per cycle (note searches stop at the first match) and then
// drain a two-stage multiply pipeline before a tick's word is offered.
// The walk over the voice file sets the rate: one request at a time.
// Reset clears all voices; the wave and step memories hold nothing defined
// until loaded. While the receiver stalls, the DAC word holds and no new
// request is taken.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_synth import pws_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         req_type,
	input  wire logic [3:0]         channel,
	input  wire logic [6:0]         key,
	input  wire logic [6:0]         velocity,
	input  wire logic [13:0]        wheel_value,
	input  wire logic [9:0]         table_index,
	input  wire logic signed [15:0] wave_data,
	input  wire logic [25:0]        step_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [11:0]             dac_code
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     load_wave, load_step;

	pws_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .req_type, .velocity, .in_stall,
		.out_valid, .out_stall, .cmd, .stat, .load_wave, .load_step
	);

	pws_datapath u_dp (
		.clk, .arst_n, .cmd, .stat, .channel, .key, .velocity, .wheel_value,
		.table_index, .wave_data, .step_data, .load_wave, .load_step, .dac_code
	);

endmodule
`default_nettype wire

>>> verif/pws_mix_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable synth checker
// Watches the request and DAC channels of the synth, keeps its own copy of
// the voice bank and tables, predicts the DAC code of every tick and compares
// each DAC word that leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
module pws_mix_checker import pws_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic [3:0]         channel,
	input  logic [6:0]         key,
	input  logic [6:0]         velocity,
	input  logic [13:0]        wheel_value,
	input  logic [9:0]         table_index,
	input  logic signed [15:0] wave_data,
	input  logic [25:0]        step_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [11:0]         dac_code,
	output int                 mismatches,
	output int                 pending,
	output int                 codes_checked
);

	localparam logic [25:0] STEP_SAT = 26'h3FFFFFF;

	// Pitch bend factors in unsigned Q1.16, 0.943874 up to 1.057552.
	localparam logic [16:0] BEND_Q16 [64] = '{
		17'd61858, 17'd61970, 17'd62081, 17'd62194, 17'd62306, 17'd62419, 17'd62531,
		17'd62644, 17'd62757, 17'd62871, 17'd62984, 17'd63098, 17'd63212, 17'd63326,
		17'd63441, 17'd63556, 17'd63670, 17'd63785, 17'd63901, 17'd64016, 17'd64132,
		17'd64248, 17'd64364, 17'd64480, 17'd64596, 17'd64713, 17'd64830, 17'd64947,
		17'd65065, 17'd65182, 17'd65300, 17'd65418, 17'd65536, 17'd65654, 17'd65773,
		17'd65892, 17'd66011, 17'd66130, 17'd66250, 17'd66369, 17'd66489, 17'd66609,
		17'd66730, 17'd66850, 17'd66971, 17'd67092, 17'd67213, 17'd67335, 17'd67456,
		17'd67578, 17'd67700, 17'd67823, 17'd67945, 17'd68068, 17'd68191, 17'd68314,
		17'd68438, 17'd68561, 17'd68685, 17'd68809, 17'd68933, 17'd69058, 17'd69183,
		17'd69308
	};

	// Shadow of the voice bank and the two tables.
	logic               v_on     [NumVoices];
	logic [6:0]         v_key    [NumVoices];
	logic [3:0]         v_chan   [NumVoices];
	logic [6:0]         v_vol    [NumVoices];
	logic [25:0]        v_step   [NumVoices];
	logic [25:0]        v_phase  [NumVoices];
	logic signed [15:0] wave_tab [WaveEntries];
	logic [25:0]        step_tab [KeyCount];

	logic [11:0] dac_queue [$];

	task automatic report(input string what, input logic [11:0] got, input logic [11:0] want);
		$display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Free the lowest active voice that plays this key, on any channel.
	task automatic release_voice(input logic [6:0] k);
		for (int v = 0; v < NumVoices; v++) begin
			if (v_on[v] && v_key[v] == k) begin
				v_on[v]   = 1'b0;
				v_chan[v] = '0;
				v_step[v] = step_tab[k];
				return;
			end
		end
	endtask

	// Apply one accepted request word to the shadow state.
	task automatic apply_request();
		int signed   mix;
		int signed   code;
		logic [63:0] scaled;
		logic [26:0] nxt;
		bit          placed;
		mix    = 0;
		placed = 0;
		case (req_type)
			REQ_TICK: begin
				for (int v = 0; v < NumVoices; v++) begin
					if (v_on[v]) begin
						nxt        = {1'b0, v_phase[v]} + {1'b0, v_step[v]};
						v_phase[v] = nxt[25:0];
						mix += (int'(wave_tab[v_phase[v][25:16]]) * int'({1'b0, v_vol[v]})) >>> 4;
					end
				end
				code = (mix >>> 10) + 2048;
				if (code > 4095)
					code = 4095;
				else if (code < 0)
					code = 0;
				dac_queue.push_back(code[11:0]);
			end
			REQ_ON: begin
				if (velocity == '0) begin
					release_voice(key);
				end else begin
					for (int v = 0; v < NumVoices; v++) begin
						if (!v_on[v] && !placed) begin
							v_key[v]   = key;
							v_step[v]  = step_tab[key];
							v_phase[v] = '0;
							v_vol[v]   = velocity;
							v_chan[v]  = channel;
							v_on[v]    = 1'b1;
							placed     = 1;
						end
					end
				end
			end
			REQ_OFF: release_voice(key);
			REQ_WHEEL: begin
				for (int v = 0; v < NumVoices; v++) begin
					if (v_on[v] && v_chan[v] == channel) begin
						scaled = (64'(step_tab[v_key[v]]) * 64'(BEND_Q16[wheel_value[13:8]])) >> 16;
						v_step[v] = (scaled > 64'(STEP_SAT)) ? STEP_SAT : scaled[25:0];
					end
				end
			end
			REQ_WAVE: wave_tab[table_index] = wave_data;
			REQ_STEP: begin
				if (table_index < KeyCount)
					step_tab[table_index[6:0]] = step_data;
			end
			default: ;
		endcase
	endtask

	// Prediction on the request channel, comparison on the DAC channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < NumVoices; v++) begin
				v_on[v]    = 1'b0;
				v_key[v]   = '0;
				v_chan[v]  = '0;
				v_vol[v]   = '0;
				v_step[v]  = '0;
				v_phase[v] = '0;
			end
			dac_queue.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (dac_queue.size() == 0) begin
					report("DAC word with nothing expected, dac_code", dac_code, '0);
				end else begin
					if (dac_code !== dac_queue[0])
						report("dac_code", dac_code, dac_queue[0]);
					void'(dac_queue.pop_front());
					codes_checked++;
				end
			end
			if (in_valid && !in_stall)
				apply_request();
			pending = dac_queue.size();
		end
	end

	initial begin
		mismatches    = 0;
		codes_checked = 0;
		pending       = 0;
	end

endmodule

>>> verif/polyphonic_wavetable_synth_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable synth testbench
// Loads the wave and step tables, runs directed note, wheel and clamp cases,
// then a random mix of requests with bursty input and a stalling DAC
// receiver. The checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_synth_tb;
	import pws_pkg::*;

	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;
	localparam int RANDOM_REQS = 200;
	localparam int IDLE_LIMIT  = 3000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         req_type = '0;
	logic [3:0]         channel = '0;
	logic [6:0]         key = '0;
	logic [6:0]         velocity = '0;
	logic [13:0]        wheel_value = '0;
	logic [9:0]         table_index = '0;
	logic signed [15:0] wave_data = '0;
	logic [25:0]        step_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [11:0]        dac_code;

	int mismatches;
	int pending;
	int codes_checked;
	int burst_left = 0;
	int words_sent = 0;
	int idle_cycles = 0;
	int stall_mode = 0;
	int mode_cycles = 0;
	int pick;

	always #5 clk = ~clk;

	polyphonic_wavetable_synth dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .channel(channel), .key(key), .velocity(velocity),
		.wheel_value(wheel_value), .table_index(table_index),
		.wave_data(wave_data), .step_data(step_data),
		.out_valid(out_valid), .out_stall(out_stall), .dac_code(dac_code)
	);

	pws_mix_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .channel(channel), .key(key), .velocity(velocity),
		.wheel_value(wheel_value), .table_index(table_index),
		.wave_data(wave_data), .step_data(step_data),
		.out_valid(out_valid), .out_stall(out_stall), .dac_code(dac_code),
		.mismatches(mismatches), .pending(pending), .codes_checked(codes_checked)
	);

	// The DAC receiver switches between no stall, light and heavy stalling.
	always @(posedge clk) begin
		if (mode_cycles == 0) begin
			stall_mode  <= $urandom_range(0, 2);
			mode_cycles <= $urandom_range(20, 120);
		end else begin
			mode_cycles <= mode_cycles - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 8);
		endcase
	end

	// Watchdog on cycles with no word moving on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Send one request word; bursts of words are split by random gaps.
	task automatic issue(input logic [2:0] rt, input int unsigned ch, input int unsigned k,
			input int unsigned vel, input int unsigned wh, input int unsigned idx,
			input int unsigned wd, input int unsigned sd);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid    <= 1'b1;
		req_type    <= rt;
		channel     <= 4'(ch);
		key         <= 7'(k);
		velocity    <= 7'(vel);
		wheel_value <= 14'(wh);
		table_index <= 10'(idx);
		wave_data   <= 16'(wd);
		step_data   <= 26'(sd);
		do @(posedge clk); while (in_stall);
		burst_left--;
		words_sent++;
	endtask

	// Fill the whole wave table with random samples.
	task automatic fill_wave();
		for (int i = 0; i < WaveEntries; i++)
			issue(REQ_WAVE, $urandom, $urandom, $urandom, $urandom, i, $urandom, $urandom);
	endtask

	// Set the low entries and the top entry, where the directed voices read, to one level.
	task automatic set_wave_span(input int unsigned level);
		for (int i = 0; i < 16; i++)
			issue(REQ_WAVE, $urandom, $urandom, $urandom, $urandom, i, level, $urandom);
		issue(REQ_WAVE, $urandom, $urandom, $urandom, $urandom, WaveEntries - 1, level,
			$urandom);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A tick with every voice idle reads no table and gives mid-scale.
		issue(REQ_TICK, 0, 0, 0, 0, 0, 0, 0);

		// Tables: random wave, steps growing with the key, top key saturates.
		fill_wave();
		for (int k = 0; k < KeyCount; k++)
			issue(REQ_STEP, $urandom, $urandom, $urandom, $urandom, k, $urandom,
				(k == KeyCount - 1) ? 'h3FFFFFF : k * 2741 + $urandom_range(0, 999));

		// Full-scale positive samples where the directed voices read.
		set_wave_span('h7FFF);

		// Sixteen notes on fifteen voices: the last one is dropped.
		issue(REQ_ON, 1, 127, 127, $urandom, $urandom, $urandom, $urandom);
		issue(REQ_ON, 0, 0, 1, $urandom, $urandom, $urandom, $urandom);
		for (int n = 2; n < 16; n++)
			issue(REQ_ON, n, n + 40, 127, $urandom, $urandom, $urandom, $urandom);
		issue(REQ_TICK, 0, 0, 0, 0, 0, 0, 0);

		// Wheel extremes; the top key on channel one saturates its step.
		issue(REQ_WHEEL, 1, $urandom, $urandom, 'h3FFF, $urandom, $urandom, $urandom);
		issue(REQ_WHEEL, 0, $urandom, $urandom, 0, $urandom, $urandom, $urandom);
		issue(REQ_TICK, 0, 0, 0, 0, 0, 0, 0);

		// Full-scale negative samples clamp at the bottom.
		set_wave_span('h8000);
		issue(REQ_TICK, 0, 0, 0, 0, 0, 0, 0);

		// Releases, a note off that matches nothing, spare codes, out-of-range step load.
		issue(REQ_OFF, $urandom, 100, $urandom, $urandom, $urandom, $urandom, $urandom);
		issue(REQ_OFF, $urandom, 127, $urandom, $urandom, $urandom, $urandom, $urandom);
		issue(REQ_ON, 15, 0, 0, $urandom, $urandom, $urandom, $urandom);
		issue(REQ_SPARE_LO, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		issue(REQ_SPARE_HI, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		issue(REQ_STEP, $urandom, $urandom, $urandom, $urandom, 1023, $urandom, 'h3FFFFFF);
		issue(REQ_TICK, 0, 0, 0, 0, 0, 0, 0);

		// Random mix: keys and channels mostly from a small pool so offs and wheels hit.
		for (int i = 0; i < RANDOM_REQS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				issue(REQ_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom);
			else if (pick < 57)
				issue(REQ_ON,
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 23),
					($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 127),
					$urandom, $urandom, $urandom, $urandom);
			else if (pick < 74)
				issue(REQ_OFF, $urandom,
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 23),
					$urandom, $urandom, $urandom, $urandom, $urandom);
			else if (pick < 84)
				issue(REQ_WHEEL,
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3),
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			else if (pick < 92)
				issue(REQ_WAVE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom);
			else if (pick < 97)
				issue(REQ_STEP, $urandom, $urandom, $urandom, $urandom,
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 127),
					$urandom,
					($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 600000));
			else
				issue($urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom);
		end
		in_valid <= 1'b0;

		// Drain, then allow the block's own latency before the verdict.
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("Sent %0d request words and checked %0d DAC codes,", words_sent, codes_checked);
		$display("covering note stealing limits, wheel extremes, clamping and table reloads.");
		if (mismatches == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
